>>> src/srsc_pkg.sv
// package for the segment / rectangle side classifier
// holds coordinate width, derived widths, edge indexes and request/result types
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package srsc_pkg;

  localparam int COORD_BITS = 16;
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int PROD_BITS  = 2 * DIFF_BITS;
  localparam int SUM_BITS   = PROD_BITS + 1;

  localparam int SIDE_CNT    = 4;
  localparam int EDGE_TOP    = 0;
  localparam int EDGE_BOTTOM = 1;
  localparam int EDGE_LEFT   = 2;
  localparam int EDGE_RIGHT  = 3;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] rect_left;
    logic signed [COORD_BITS-1:0] rect_top;
    logic signed [COORD_BITS-1:0] rect_right;
    logic signed [COORD_BITS-1:0] rect_bottom;
    logic signed [COORD_BITS-1:0] seg_x1;
    logic signed [COORD_BITS-1:0] seg_y1;
    logic signed [COORD_BITS-1:0] seg_x2;
    logic signed [COORD_BITS-1:0] seg_y2;
  } srsc_req_t;

  typedef struct packed {
    logic                fully_inside;
    logic [SIDE_CNT-1:0] side_mask;
  } srsc_res_t;

endpackage

`default_nettype wire

>>> src/segment_rectangle_side_classifier.sv
// segment / rectangle side classifier, four-stage pipeline
// a request taken at one edge passes the s1, s2, s3 and result registers; its result strobe is one cycle wide
// throughput: one request every cycle; busy stays low
// reset: synchronous active-low rst_n clears the stage valid bits and the output strobe
// the receiver cannot stall, so the pipeline never holds
// depends on srsc_pkg
`timescale 1ns / 1ps
`default_nettype none

module segment_rectangle_side_classifier (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire srsc_pkg::srsc_req_t in_data,
  output logic                    out_strobe,
  output srsc_pkg::srsc_res_t     out_data
);
  import srsc_pkg::*;

  function automatic logic signed [DIFF_BITS-1:0] sub(
    input logic signed [COORD_BITS-1:0] a,
    input logic signed [COORD_BITS-1:0] b
  );
    sub = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
  endfunction

  // ratio num/den within [0,1], den nonzero
  function automatic logic in_unit(
    input logic signed [SUM_BITS-1:0] num,
    input logic signed [SUM_BITS-1:0] den
  );
    if (!den[SUM_BITS-1]) begin
      in_unit = !num[SUM_BITS-1] && (num <= den);
    end else begin
      in_unit = (num[SUM_BITS-1] || (num == '0)) && (num >= den);
    end
  endfunction

  // stage 0: inside test on the raw request
  logic inside_now;
  always_comb begin
    inside_now = (in_data.seg_x1 >= in_data.rect_left) && (in_data.seg_x1 <= in_data.rect_right)
              && (in_data.seg_y1 >= in_data.rect_top)  && (in_data.seg_y1 <= in_data.rect_bottom)
              && (in_data.seg_x2 >= in_data.rect_left) && (in_data.seg_x2 <= in_data.rect_right)
              && (in_data.seg_y2 >= in_data.rect_top)  && (in_data.seg_y2 <= in_data.rect_bottom);
  end

  // stage 1: differences
  logic                        s1_valid_r;
  logic                        s1_inside_r;
  logic signed [DIFF_BITS-1:0] s1_bx_r, s1_by_r;
  logic signed [DIFF_BITS-1:0] s1_len_r  [SIDE_CNT];
  logic signed [DIFF_BITS-1:0] s1_denf_r [SIDE_CNT];
  logic signed [DIFF_BITS-1:0] s1_nbf_r  [SIDE_CNT];
  logic signed [DIFF_BITS-1:0] s1_cx_r   [SIDE_CNT];
  logic signed [DIFF_BITS-1:0] s1_cy_r   [SIDE_CNT];

  logic signed [DIFF_BITS-1:0] s1_len_nxt  [SIDE_CNT];
  logic signed [DIFF_BITS-1:0] s1_denf_nxt [SIDE_CNT];
  logic signed [DIFF_BITS-1:0] s1_nbf_nxt  [SIDE_CNT];
  logic signed [DIFF_BITS-1:0] s1_cx_nxt   [SIDE_CNT];
  logic signed [DIFF_BITS-1:0] s1_cy_nxt   [SIDE_CNT];

  // horizontal edges: den = -len*by, nb = len*cy
  // vertical edges:   den =  len*bx, nb = -len*cx
  always_comb begin
    s1_len_nxt[EDGE_TOP]     = sub(in_data.rect_right, in_data.rect_left);
    s1_len_nxt[EDGE_BOTTOM]  = sub(in_data.rect_right, in_data.rect_left);
    s1_len_nxt[EDGE_LEFT]    = sub(in_data.rect_bottom, in_data.rect_top);
    s1_len_nxt[EDGE_RIGHT]   = sub(in_data.rect_bottom, in_data.rect_top);

    s1_denf_nxt[EDGE_TOP]    = sub(in_data.seg_y1, in_data.seg_y2);
    s1_denf_nxt[EDGE_BOTTOM] = sub(in_data.seg_y1, in_data.seg_y2);
    s1_denf_nxt[EDGE_LEFT]   = sub(in_data.seg_x2, in_data.seg_x1);
    s1_denf_nxt[EDGE_RIGHT]  = sub(in_data.seg_x2, in_data.seg_x1);

    s1_cx_nxt[EDGE_TOP]      = sub(in_data.rect_left, in_data.seg_x2);
    s1_cx_nxt[EDGE_BOTTOM]   = sub(in_data.rect_left, in_data.seg_x2);
    s1_cx_nxt[EDGE_LEFT]     = sub(in_data.rect_left, in_data.seg_x2);
    s1_cx_nxt[EDGE_RIGHT]    = sub(in_data.rect_right, in_data.seg_x2);

    s1_cy_nxt[EDGE_TOP]      = sub(in_data.rect_top, in_data.seg_y2);
    s1_cy_nxt[EDGE_BOTTOM]   = sub(in_data.rect_bottom, in_data.seg_y2);
    s1_cy_nxt[EDGE_LEFT]     = sub(in_data.rect_top, in_data.seg_y2);
    s1_cy_nxt[EDGE_RIGHT]    = sub(in_data.rect_top, in_data.seg_y2);

    s1_nbf_nxt[EDGE_TOP]     = sub(in_data.rect_top, in_data.seg_y2);
    s1_nbf_nxt[EDGE_BOTTOM]  = sub(in_data.rect_bottom, in_data.seg_y2);
    s1_nbf_nxt[EDGE_LEFT]    = sub(in_data.seg_x2, in_data.rect_left);
    s1_nbf_nxt[EDGE_RIGHT]   = sub(in_data.seg_x2, in_data.rect_right);
  end

  always_ff @(posedge clk) begin
    s1_inside_r <= inside_now;
    s1_bx_r     <= sub(in_data.seg_x2, in_data.seg_x1);
    s1_by_r     <= sub(in_data.seg_y2, in_data.seg_y1);
    s1_len_r    <= s1_len_nxt;
    s1_denf_r   <= s1_denf_nxt;
    s1_nbf_r    <= s1_nbf_nxt;
    s1_cx_r     <= s1_cx_nxt;
    s1_cy_r     <= s1_cy_nxt;
  end

  // stage 2: products
  logic                        s2_valid_r;
  logic                        s2_inside_r;
  logic signed [PROD_BITS-1:0] s2_pd_r [SIDE_CNT];
  logic signed [PROD_BITS-1:0] s2_pn_r [SIDE_CNT];
  logic signed [PROD_BITS-1:0] s2_q1_r [SIDE_CNT];
  logic signed [PROD_BITS-1:0] s2_q2_r [SIDE_CNT];

  always_ff @(posedge clk) begin
    s2_inside_r <= s1_inside_r;
    for (int e = 0; e < SIDE_CNT; e++) begin
      s2_pd_r[e] <= PROD_BITS'(s1_len_r[e]) * PROD_BITS'(s1_denf_r[e]);
      s2_pn_r[e] <= PROD_BITS'(s1_len_r[e]) * PROD_BITS'(s1_nbf_r[e]);
      s2_q1_r[e] <= PROD_BITS'(s1_by_r) * PROD_BITS'(s1_cx_r[e]);
      s2_q2_r[e] <= PROD_BITS'(s1_bx_r) * PROD_BITS'(s1_cy_r[e]);
    end
  end

  // stage 3: cross product sums
  logic                       s3_valid_r;
  logic                       s3_inside_r;
  logic signed [SUM_BITS-1:0] s3_den_r [SIDE_CNT];
  logic signed [SUM_BITS-1:0] s3_na_r  [SIDE_CNT];
  logic signed [SUM_BITS-1:0] s3_nb_r  [SIDE_CNT];

  always_ff @(posedge clk) begin
    s3_inside_r <= s2_inside_r;
    for (int e = 0; e < SIDE_CNT; e++) begin
      s3_den_r[e] <= {s2_pd_r[e][PROD_BITS-1], s2_pd_r[e]};
      s3_nb_r[e]  <= {s2_pn_r[e][PROD_BITS-1], s2_pn_r[e]};
      s3_na_r[e]  <= {s2_q1_r[e][PROD_BITS-1], s2_q1_r[e]}
                   - {s2_q2_r[e][PROD_BITS-1], s2_q2_r[e]};
    end
  end

  // stage 4: range checks and result register
  logic [SIDE_CNT-1:0] hit_nxt;
  srsc_res_t           out_data_nxt;
  srsc_res_t           out_data_r;
  logic                out_strobe_r;

  always_comb begin
    for (int e = 0; e < SIDE_CNT; e++) begin
      hit_nxt[e] = (s3_den_r[e] != '0) && in_unit(s3_na_r[e], s3_den_r[e])
                && in_unit(s3_nb_r[e], s3_den_r[e]);
    end
    out_data_nxt.fully_inside = s3_inside_r;
    out_data_nxt.side_mask    = s3_inside_r ? '0 : hit_nxt;
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      s2_valid_r   <= 1'b0;
      s3_valid_r   <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      s1_valid_r   <= start && !busy;
      s2_valid_r   <= s1_valid_r;
      s3_valid_r   <= s2_valid_r;
      out_strobe_r <= s3_valid_r;
    end
  end

  assign busy       = 1'b0;
  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

`ifndef SYNTHESIS
  a_strobe_follows_request: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start, 4))
    else $error("result strobe without a request four cycles earlier");

  a_inside_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_data.fully_inside == $past(inside_now, 4)))
    else $error("inside flag not aligned with its request");

  a_inside_clears_mask: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_data.fully_inside) |-> (out_data.side_mask == '0))
    else $error("side mask set on an inside result");

  a_flat_rect_no_horizontal_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && $past(in_data.rect_left == in_data.rect_right, 4))
      |-> (out_data.side_mask[EDGE_TOP] == 1'b0 && out_data.side_mask[EDGE_BOTTOM] == 1'b0))
    else $error("zero-length horizontal edge reported a hit");
`endif

endmodule

`default_nettype wire
